FILE: hw/rtl/efc_pkg.sv
// Shared types, codes and constants for the four-floor elevator controller.
// Used by the configuration registers and the top level.
// Has no dependencies.
package efc_pkg;

    localparam int FLOORS      = 4;
    localparam int FLOOR_W     = 3;
    localparam int FLOOR_IDX_W = $clog2(FLOORS);
    localparam int CFG_W       = 16;
    localparam int ADDR_W      = 5;
    localparam int APB_DATA_W  = 32;
    localparam int DUTY_W      = 7;
    localparam int DRIVE_W     = 2;
    localparam int CHASE_N     = 4;
    localparam int CHASE_W     = $clog2(CHASE_N);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic [DRIVE_W-1:0] DOOR_OFF     = 2'd0;
    localparam logic [DRIVE_W-1:0] DOOR_CLOSING = 2'd1;
    localparam logic [DRIVE_W-1:0] DOOR_OPENING = 2'd2;
    localparam logic [DRIVE_W-1:0] LIFT_OFF     = 2'd0;
    localparam logic [DRIVE_W-1:0] LIFT_UP      = 2'd1;
    localparam logic [DRIVE_W-1:0] LIFT_DOWN    = 2'd2;

    localparam logic [DUTY_W-1:0] DUTY_OFF          = 7'd0;
    localparam logic [DUTY_W-1:0] DUTY_DOOR_CLOSING = 7'd50;
    localparam logic [DUTY_W-1:0] DUTY_DOOR_OPENING = 7'd60;
    localparam logic [DUTY_W-1:0] DUTY_LIFT_UP      = 7'd80;
    localparam logic [DUTY_W-1:0] DUTY_LIFT_DOWN    = 7'd60;

    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] DOOR_CLOSE_RESET   = 16'd4000;
    localparam logic [CFG_W-1:0] TRAVEL_RESET       = 16'd6000;
    localparam logic [CFG_W-1:0] DOOR_OPEN_RESET    = 16'd4000;
    localparam logic [CFG_W-1:0] CHASE_STEP_RESET   = 16'd250;

    typedef enum logic [2:0] {
        REG_IDLE_TIMEOUT = 3'd0,
        REG_DOOR_CLOSE   = 3'd1,
        REG_TRAVEL       = 3'd2,
        REG_DOOR_OPEN    = 3'd3,
        REG_CHASE_STEP   = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        MODE_COMMAND = 4'b0001,
        MODE_CLOSING = 4'b0010,
        MODE_TRAVEL  = 4'b0100,
        MODE_OPENING = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] idle_timeout_ticks;
        logic [CFG_W-1:0] door_close_ticks;
        logic [CFG_W-1:0] travel_ticks;
        logic [CFG_W-1:0] door_open_ticks;
        logic [CFG_W-1:0] chase_step_ticks;
    } cfg_t;

    typedef struct packed {
        logic               opcode;
        logic [FLOOR_W-1:0] button_floor;
    } in_item_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] current_floor;
        logic [FLOORS-1:0]  request_lights;
        logic               serving;
        logic [DRIVE_W-1:0] door_drive;
        logic [DUTY_W-1:0]  door_duty;
        logic [DRIVE_W-1:0] lift_drive;
        logic [DUTY_W-1:0]  lift_duty;
        logic [CHASE_N-1:0] chase_lights;
    } out_item_t;

    typedef struct packed {
        logic               found;
        logic [FLOOR_W-1:0] floor_num;
        logic               down;
    } pick_t;

    // Nearest pending floor above when going up is allowed, else the nearest one below.
    function automatic pick_t pick_next(logic [FLOOR_W-1:0] floor_now,
                                        logic [FLOORS-1:0] pending, logic try_up);
        pick_t up;
        pick_t dn;
        up = '0;
        dn = '0;
        for (int f = FLOORS; f >= 1; f--)
        begin
            if (FLOOR_W'(f) > floor_now && pending[f-1])
            begin
                up.found     = 1'b1;
                up.floor_num = FLOOR_W'(f);
                up.down      = 1'b0;
            end
        end
        for (int f = 1; f <= FLOORS; f++)
        begin
            if (FLOOR_W'(f) < floor_now && pending[f-1])
            begin
                dn.found     = 1'b1;
                dn.floor_num = FLOOR_W'(f);
                dn.down      = 1'b1;
            end
        end
        return (try_up && up.found) ? up : dn;
    endfunction

endpackage

FILE: hw/rtl/efc_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// The payload type is set per instance, normally from efc_pkg.
interface efc_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/efc_cfg_regs.sv
// APB-style configuration register file for the elevator controller timing.
// Depends on efc_pkg for the register map, widths and reset values.
module efc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [efc_pkg::ADDR_W-1:0]      paddr,
    input  logic [efc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [efc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output efc_pkg::cfg_t                   cfg
);

    efc_pkg::cfg_t        cfg_reg;
    efc_pkg::reg_index_t  reg_index;
    logic                 wr_en;
    logic [efc_pkg::CFG_W-1:0] wr_data;
    logic [efc_pkg::CFG_W-1:0] rd_data;

    assign pready    = 1'b1;
    assign reg_index = efc_pkg::reg_index_t'(paddr[efc_pkg::ADDR_W-1:2]);
    assign wr_en     = psel && penable && pwrite && pready;
    assign wr_data   = pwdata[efc_pkg::CFG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_timeout_ticks <= efc_pkg::IDLE_TIMEOUT_RESET;
            cfg_reg.door_close_ticks   <= efc_pkg::DOOR_CLOSE_RESET;
            cfg_reg.travel_ticks       <= efc_pkg::TRAVEL_RESET;
            cfg_reg.door_open_ticks    <= efc_pkg::DOOR_OPEN_RESET;
            cfg_reg.chase_step_ticks   <= efc_pkg::CHASE_STEP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                efc_pkg::REG_IDLE_TIMEOUT: cfg_reg.idle_timeout_ticks <= wr_data;
                efc_pkg::REG_DOOR_CLOSE:   cfg_reg.door_close_ticks   <= wr_data;
                efc_pkg::REG_TRAVEL:       cfg_reg.travel_ticks       <= wr_data;
                efc_pkg::REG_DOOR_OPEN:    cfg_reg.door_open_ticks    <= wr_data;
                efc_pkg::REG_CHASE_STEP:   cfg_reg.chase_step_ticks   <= wr_data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            efc_pkg::REG_IDLE_TIMEOUT: rd_data = cfg_reg.idle_timeout_ticks;
            efc_pkg::REG_DOOR_CLOSE:   rd_data = cfg_reg.door_close_ticks;
            efc_pkg::REG_TRAVEL:       rd_data = cfg_reg.travel_ticks;
            efc_pkg::REG_DOOR_OPEN:    rd_data = cfg_reg.door_open_ticks;
            efc_pkg::REG_CHASE_STEP:   rd_data = cfg_reg.chase_step_ticks;
            default:                   rd_data = '0;
        endcase
    end

    assign prdata = efc_pkg::APB_DATA_W'(rd_data);
    assign cfg    = cfg_reg;

endmodule

FILE: hw/rtl/four_floor_elevator_controller_top.sv
// Top level of the four-floor elevator controller: request latching, stop sequencing,
// door and lift drive outputs and the chasing light.
// Depends on efc_pkg, efc_stream_if and efc_cfg_regs.
//
// Usage: each input transaction on in_ch is one timebase tick (opcode 0) or one completed
// button press (opcode 1 with button_floor). Every input transaction yields exactly one
// output transaction on out_ch with the floor, request lights, mode and motor drive state
// as they stand after that input. The user writes the timing registers over the
// APB-style port only while the block is idle; the block itself does not enforce
// this. pready is always high. Each input is held in one input register while the
// state update is worked out in the single logic stage after it, and its result is
// captured in one result register, from which it leaves on out_ch.
// Throughput is one transaction per cycle while out_ch accepts results; the state registers
// feed the next item directly. When the receiver stalls, the result register holds its
// transaction and the input register still takes one more; in_ch.ready then drops until
// out_ch drains. Reset clears both registers' valid flags, returns the car to floor 1 in
// command mode with no pending requests, and loads the default timing registers.
module four_floor_elevator_controller_top #(
    parameter int TIMER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    efc_stream_if.sink                      in_ch,
    efc_stream_if.source                    out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [efc_pkg::ADDR_W-1:0]      paddr,
    input  logic [efc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [efc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CW = (TIMER_BITS > efc_pkg::CFG_W) ? TIMER_BITS : efc_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    function automatic logic [TIMER_BITS:0] count_tick(logic [TIMER_BITS-1:0] ctr,
                                                       logic [efc_pkg::CFG_W-1:0] limit);
        logic [CW-1:0]         lim;
        logic [TIMER_BITS-1:0] nxt;
        lim = (CW'(limit) > CW'(TIMER_MAX)) ? CW'(TIMER_MAX) : CW'(limit);
        nxt = (ctr != TIMER_MAX) ? ctr + TIMER_BITS'(1) : ctr;
        if (CW'(nxt) >= lim)
            return {1'b1, {TIMER_BITS{1'b0}}};
        return {1'b0, nxt};
    endfunction

    efc_pkg::cfg_t cfg;

    efc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic                s1_valid_reg;
    efc_pkg::in_item_t   s1_item_reg;
    logic                out_valid_reg;
    efc_pkg::out_item_t  out_item_reg;
    logic                s1_adv;
    logic                proc;

    efc_pkg::mode_t                     mode_reg, mode_next;
    logic                               sweep_down_reg, sweep_down_next;
    logic [efc_pkg::FLOOR_W-1:0]        floor_reg, floor_next;
    logic [efc_pkg::FLOOR_W-1:0]        target_reg, target_next;
    logic [efc_pkg::FLOORS-1:0]         pending_reg, pending_next;
    logic [TIMER_BITS-1:0]              phase_timer_reg, phase_timer_next;
    logic [TIMER_BITS-1:0]              idle_timer_reg, idle_timer_next;
    logic [efc_pkg::CHASE_W-1:0]        chase_pos_reg, chase_pos_next;
    logic [TIMER_BITS-1:0]              chase_timer_reg, chase_timer_next;
    logic                               chase_on_reg, chase_on_next;

    logic [efc_pkg::CFG_W-1:0]          phase_limit;
    logic [TIMER_BITS:0]                idle_cnt;
    logic [TIMER_BITS:0]                phase_cnt;
    logic [TIMER_BITS:0]                chase_cnt;
    efc_pkg::pick_t                     pick_up;
    efc_pkg::pick_t                     pick_resume;
    logic [efc_pkg::FLOOR_W-1:0]        bf;
    logic [efc_pkg::FLOOR_IDX_W-1:0]    bf_idx;
    logic [efc_pkg::FLOOR_IDX_W-1:0]    target_idx;
    logic [efc_pkg::FLOOR_IDX_W-1:0]    floor_idx;
    logic [efc_pkg::CHASE_W-1:0]        shown;
    efc_pkg::out_item_t                 out_next;

    assign s1_adv      = !out_valid_reg || out_ch.ready;
    assign proc        = s1_valid_reg && s1_adv;
    assign in_ch.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            s1_item_reg <= in_ch.payload;
    end

    always_comb
    begin
        unique case (mode_reg)
            efc_pkg::MODE_CLOSING: phase_limit = cfg.door_close_ticks;
            efc_pkg::MODE_TRAVEL:  phase_limit = cfg.travel_ticks;
            default:               phase_limit = cfg.door_open_ticks;
        endcase
    end

    assign idle_cnt    = count_tick(idle_timer_reg, cfg.idle_timeout_ticks);
    assign phase_cnt   = count_tick(phase_timer_reg, phase_limit);
    assign chase_cnt   = count_tick(chase_timer_reg, cfg.chase_step_ticks);
    assign pick_up     = efc_pkg::pick_next(floor_reg, pending_reg, 1'b1);
    assign pick_resume = efc_pkg::pick_next(floor_reg, pending_reg, !sweep_down_reg);
    assign bf          = s1_item_reg.button_floor;
    assign bf_idx      = efc_pkg::FLOOR_IDX_W'(bf - efc_pkg::FLOOR_W'(1));
    assign target_idx  = efc_pkg::FLOOR_IDX_W'(target_reg - efc_pkg::FLOOR_W'(1));
    assign floor_idx   = efc_pkg::FLOOR_IDX_W'(floor_reg - efc_pkg::FLOOR_W'(1));

    always_comb
    begin
        mode_next        = mode_reg;
        sweep_down_next  = sweep_down_reg;
        floor_next       = floor_reg;
        target_next      = target_reg;
        pending_next     = pending_reg;
        phase_timer_next = phase_timer_reg;
        idle_timer_next  = idle_timer_reg;
        chase_pos_next   = chase_pos_reg;
        chase_timer_next = chase_timer_reg;
        chase_on_next    = chase_on_reg;

        unique case (mode_reg)
            efc_pkg::MODE_COMMAND:
            begin
                if (s1_item_reg.opcode == efc_pkg::OP_PRESS)
                begin
                    if (bf >= efc_pkg::FLOOR_W'(1) && bf <= efc_pkg::FLOOR_W'(efc_pkg::FLOORS)
                        && bf != floor_reg)
                        pending_next[bf_idx] = 1'b1;
                    idle_timer_next = '0;
                end
                else
                begin
                    idle_timer_next = idle_cnt[TIMER_BITS-1:0];
                    if (idle_cnt[TIMER_BITS] && pick_up.found)
                    begin
                        target_next      = pick_up.floor_num;
                        sweep_down_next  = pick_up.down;
                        mode_next        = efc_pkg::MODE_CLOSING;
                        phase_timer_next = '0;
                    end
                end
            end
            efc_pkg::MODE_CLOSING:
            begin
                if (s1_item_reg.opcode == efc_pkg::OP_TICK)
                begin
                    phase_timer_next = phase_cnt[TIMER_BITS-1:0];
                    if (phase_cnt[TIMER_BITS])
                    begin
                        mode_next        = efc_pkg::MODE_TRAVEL;
                        chase_timer_next = '0;
                        chase_on_next    = 1'b0;
                    end
                end
            end
            efc_pkg::MODE_TRAVEL:
            begin
                if (s1_item_reg.opcode == efc_pkg::OP_TICK)
                begin
                    chase_timer_next = chase_cnt[TIMER_BITS-1:0];
                    if (chase_cnt[TIMER_BITS])
                    begin
                        chase_on_next  = 1'b1;
                        chase_pos_next = sweep_down_reg
                                       ? chase_pos_reg - efc_pkg::CHASE_W'(1)
                                       : chase_pos_reg + efc_pkg::CHASE_W'(1);
                    end
                    phase_timer_next = phase_cnt[TIMER_BITS-1:0];
                    if (phase_cnt[TIMER_BITS])
                    begin
                        chase_on_next            = 1'b0;
                        pending_next[target_idx] = 1'b0;
                        floor_next               = target_reg;
                        mode_next                = efc_pkg::MODE_OPENING;
                    end
                end
            end
            efc_pkg::MODE_OPENING:
            begin
                if (s1_item_reg.opcode == efc_pkg::OP_TICK)
                begin
                    phase_timer_next = phase_cnt[TIMER_BITS-1:0];
                    if (phase_cnt[TIMER_BITS])
                    begin
                        if (pick_resume.found)
                        begin
                            target_next      = pick_resume.floor_num;
                            sweep_down_next  = pick_resume.down;
                            mode_next        = efc_pkg::MODE_CLOSING;
                            phase_timer_next = '0;
                        end
                        else
                        begin
                            mode_next       = efc_pkg::MODE_COMMAND;
                            idle_timer_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                mode_next = efc_pkg::MODE_COMMAND;
            end
        endcase
    end

    assign shown = sweep_down_next ? chase_pos_next + efc_pkg::CHASE_W'(1)
                                   : chase_pos_next - efc_pkg::CHASE_W'(1);

    always_comb
    begin
        out_next.current_floor  = floor_next;
        out_next.request_lights = pending_next;
        out_next.serving        = (mode_next != efc_pkg::MODE_COMMAND);
        out_next.door_drive     = efc_pkg::DOOR_OFF;
        out_next.door_duty      = efc_pkg::DUTY_OFF;
        out_next.lift_drive     = efc_pkg::LIFT_OFF;
        out_next.lift_duty      = efc_pkg::DUTY_OFF;
        out_next.chase_lights   = '0;
        unique case (mode_next)
            efc_pkg::MODE_CLOSING:
            begin
                out_next.door_drive = efc_pkg::DOOR_CLOSING;
                out_next.door_duty  = efc_pkg::DUTY_DOOR_CLOSING;
            end
            efc_pkg::MODE_OPENING:
            begin
                out_next.door_drive = efc_pkg::DOOR_OPENING;
                out_next.door_duty  = efc_pkg::DUTY_DOOR_OPENING;
            end
            efc_pkg::MODE_TRAVEL:
            begin
                out_next.lift_drive = sweep_down_next ? efc_pkg::LIFT_DOWN : efc_pkg::LIFT_UP;
                out_next.lift_duty  = sweep_down_next ? efc_pkg::DUTY_LIFT_DOWN
                                                      : efc_pkg::DUTY_LIFT_UP;
                if (chase_on_next)
                    out_next.chase_lights = efc_pkg::CHASE_N'(1) << shown;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= efc_pkg::MODE_COMMAND;
            sweep_down_reg  <= 1'b1;
            floor_reg       <= efc_pkg::FLOOR_W'(1);
            target_reg      <= efc_pkg::FLOOR_W'(1);
            pending_reg     <= '0;
            phase_timer_reg <= '0;
            idle_timer_reg  <= '0;
            chase_pos_reg   <= '0;
            chase_timer_reg <= '0;
            chase_on_reg    <= 1'b0;
        end
        else if (proc)
        begin
            mode_reg        <= mode_next;
            sweep_down_reg  <= sweep_down_next;
            floor_reg       <= floor_next;
            target_reg      <= target_next;
            pending_reg     <= pending_next;
            phase_timer_reg <= phase_timer_next;
            idle_timer_reg  <= idle_timer_next;
            chase_pos_reg   <= chase_pos_next;
            chase_timer_reg <= chase_timer_next;
            chase_on_reg    <= chase_on_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
            out_item_reg <= out_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    // The car never holds a pending request for the floor it is standing at.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg[floor_idx])
        else $error("pending request latched for the current floor");

    // While a stop is in progress the sweep direction points from the floor to the target.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == efc_pkg::MODE_CLOSING || mode_reg == efc_pkg::MODE_TRAVEL) |->
        (sweep_down_reg ? (target_reg < floor_reg) : (target_reg > floor_reg)))
        else $error("sweep direction disagrees with the target floor");

    // Controller state moves only when a transaction is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> ($stable(pending_reg) && $stable(floor_reg) && $stable(mode_reg)))
        else $error("controller state changed without a processed transaction");

    // A stalled result is never overwritten by the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !proc)
        else $error("result register loaded while its transaction was stalled");

endmodule
